// File: rtl/core/cpdc_pkg.sv
package cpdc_pkg;

	// register widths
	localparam int GAIN_W   = 16;
	localparam int LEVEL_W  = 15;
	localparam int PERIOD_W = 16;
	localparam int INT_W    = 48;
	localparam int DUTY_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// fixed point positions
	localparam int INT_SHIFT = 24;
	localparam int REF_FRAC  = 8;

	localparam int DATA_WIDTH_DEF = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_KP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLT_KI  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURR_KP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CURR_KI  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_V_TARGET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_I_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd6;

	// reset values
	localparam logic [LEVEL_W-1:0]  I_LIMIT_RST = 15'd2560;
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd1678;

	// duty of 1.0 in Q.16 and in Q1.15
	localparam logic [16:0]         DUTY_ONE_Q16 = 17'd65536;
	localparam logic [DUTY_W-1:0]   DUTY_MAX     = 16'd32768;

	typedef struct packed {
		logic load;
		logic step;
	} mac_ctrl_t;

endpackage

// File: rtl/core/cpdc_mac.sv
module cpdc_mac import cpdc_pkg::*; #(
	parameter int MCAND_W = 17
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mac_ctrl_t                          ctrl,
	input  logic signed [MCAND_W-1:0]          mcand,
	input  logic        [GAIN_W-1:0]           mult,
	output logic signed [MCAND_W+GAIN_W:0]     product
);

	localparam int PROD_W = MCAND_W + GAIN_W + 1;

	logic signed [MCAND_W-1:0] mcand_q;
	logic        [GAIN_W-1:0]  mult_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [PROD_W-1:0]  addend;
	logic                      busy_q;

	// msb first: one multiplier bit per cycle while ctrl.step is high
	assign addend = mult_q[GAIN_W-1] ?
		$signed({{(PROD_W-MCAND_W){mcand_q[MCAND_W-1]}}, mcand_q}) : '0;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mcand_q <= mcand;
			mult_q  <= mult;
			acc_q   <= '0;
		end else if (ctrl.step) begin
			mult_q <= {mult_q[GAIN_W-2:0], 1'b0};
			acc_q  <= (acc_q <<< 1) + addend;
		end
	end

	// tracks whether an operand set is in flight, for debug visibility
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
		end else if (ctrl.step && mult_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	assign product = busy_q ? acc_q : acc_q;

endmodule

// File: rtl/core/cascaded_pi_duty_controller_unit.sv
// sequence: a sample transfer starts two rounds of 16-bit bit-serial
// multiplication (outer loop, then inner loop), each closed by a finish step;
// one sample at a time, the next is taken once the result enters the output slot
// reset: arst_n clears both integrators, the registers to their defaults
// and the output slot; no clearing pass, the block is ready right after reset
module cascaded_pi_duty_controller_unit import cpdc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// v_meas, i_meas
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// duty, current_ref
	output logic [31:0]                            m_axis_tdata,
	// ref_clamped, duty_clamped
	output logic [1:0]                             m_axis_tuser,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]                   cfg_index,
	input  logic [CFG_DATA_W-1:0]                  cfg_data
);

	localparam int EW     = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 1;
	localparam int PP_W   = EW + GAIN_W + 1;
	localparam int PI_W   = INT_W + GAIN_W + 1;
	localparam int IS_W   = PI_W - INT_SHIFT;
	localparam int RAW_W  = ((PP_W > IS_W) ? PP_W : IS_W) + 1;
	localparam int SUM_W  = ((PP_W > INT_W) ? PP_W : INT_W) + 1;
	localparam int CNT_W  = $clog2(GAIN_W);

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO =
		{{(SUM_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_VLOOP = 3'd1;
	localparam logic [2:0] ST_VFIN  = 3'd2;
	localparam logic [2:0] ST_VLOAD = 3'd3;
	localparam logic [2:0] ST_ILOOP = 3'd4;
	localparam logic [2:0] ST_IFIN  = 3'd5;

	// configuration
	logic [GAIN_W-1:0]   volt_kp_q, volt_ki_q, curr_kp_q, curr_ki_q;
	logic [LEVEL_W-1:0]  volt_target_q, current_limit_q;
	logic [PERIOD_W-1:0] sample_period_q;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [INT_W-1:0] vi_q, ci_q;
	logic signed [DATA_WIDTH-1:0] i_q;
	logic [LEVEL_W-1:0]  iref_q;
	logic                rclip_q;

	logic                out_valid_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [LEVEL_W-1:0]  cref_q;
	logic                oref_clip_q, oduty_clip_q;

	logic                in_xfer, slot_free, last_step;
	logic signed [DATA_WIDTH-1:0] v_in, i_in;
	logic signed [EW-1:0] err;
	logic signed [INT_W-1:0] int_in;
	logic [GAIN_W-1:0]   kp_in, ki_in;
	mac_ctrl_t           mac_ctrl;
	logic signed [PP_W-1:0] p_prop, p_upd;
	logic signed [PI_W-1:0] p_int;

	logic signed [RAW_W-1:0] raw;
	logic signed [RAW_W-1:0] lim_ext;
	logic signed [SUM_W-1:0] int_sum;
	logic signed [INT_W-1:0] int_sat;
	logic [LEVEL_W-1:0]  iref_d;
	logic                rclip_d;
	logic [DUTY_W-1:0]   duty_d;
	logic                dclip_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_kp_q       <= '0;
			volt_ki_q       <= '0;
			curr_kp_q       <= '0;
			curr_ki_q       <= '0;
			volt_target_q   <= '0;
			current_limit_q <= I_LIMIT_RST;
			sample_period_q <= PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VOLT_KP:  volt_kp_q       <= cfg_data;
				CFG_VOLT_KI:  volt_ki_q       <= cfg_data;
				CFG_CURR_KP:  curr_kp_q       <= cfg_data;
				CFG_CURR_KI:  curr_ki_q       <= cfg_data;
				CFG_V_TARGET: volt_target_q   <= cfg_data[LEVEL_W-1:0];
				CFG_I_LIMIT:  current_limit_q <= cfg_data[LEVEL_W-1:0];
				CFG_PERIOD:   sample_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign last_step     = (cnt_q == CNT_W'(GAIN_W - 1));

	assign v_in = $signed(s_axis_tdata[DATA_WIDTH-1:0]);
	assign i_in = $signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);

	// operand select: outer loop at transfer, inner loop after the reference is known
	always_comb begin
		if (state_q == ST_VLOAD) begin
			err    = EW'($signed({1'b0, iref_q})) - EW'(i_q);
			int_in = ci_q;
			kp_in  = curr_kp_q;
			ki_in  = curr_ki_q;
		end else begin
			err    = EW'($signed({1'b0, volt_target_q})) - EW'(v_in);
			int_in = vi_q;
			kp_in  = volt_kp_q;
			ki_in  = volt_ki_q;
		end
	end

	assign mac_ctrl.load = in_xfer || (state_q == ST_VLOAD);
	assign mac_ctrl.step = (state_q == ST_VLOOP) || (state_q == ST_ILOOP);

	cpdc_mac #(.MCAND_W(EW)) u_mac_prop (
		.clk(clk), .arst_n(arst_n), .ctrl(mac_ctrl),
		.mcand(err), .mult(kp_in), .product(p_prop)
	);

	cpdc_mac #(.MCAND_W(INT_W)) u_mac_int (
		.clk(clk), .arst_n(arst_n), .ctrl(mac_ctrl),
		.mcand(int_in), .mult(ki_in), .product(p_int)
	);

	cpdc_mac #(.MCAND_W(EW)) u_mac_upd (
		.clk(clk), .arst_n(arst_n), .ctrl(mac_ctrl),
		.mcand(err), .mult(sample_period_q), .product(p_upd)
	);

	// arithmetic shift floors the integral term
	assign raw     = RAW_W'(p_prop) + RAW_W'(p_int >>> INT_SHIFT);
	assign lim_ext = RAW_W'($signed({1'b0, current_limit_q, {REF_FRAC{1'b0}}}));

	always_comb begin
		if (raw[RAW_W-1]) begin
			iref_d  = '0;
			rclip_d = 1'b1;
		end else if (raw > lim_ext) begin
			iref_d  = current_limit_q;
			rclip_d = 1'b1;
		end else begin
			iref_d  = raw[REF_FRAC+LEVEL_W-1:REF_FRAC];
			rclip_d = 1'b0;
		end
	end

	always_comb begin
		if (raw[RAW_W-1]) begin
			duty_d  = '0;
			dclip_d = 1'b1;
		end else if (raw > RAW_W'($signed({1'b0, DUTY_ONE_Q16}))) begin
			duty_d  = DUTY_MAX;
			dclip_d = 1'b1;
		end else begin
			duty_d  = raw[DUTY_W:1];
			dclip_d = 1'b0;
		end
	end

	// one saturating adder serves both integrators
	assign int_sum = SUM_W'((state_q == ST_IFIN) ? ci_q : vi_q) + SUM_W'(p_upd);

	always_comb begin
		if (int_sum > SAT_HI) begin
			int_sat = SAT_HI[INT_W-1:0];
		end else if (int_sum < SAT_LO) begin
			int_sat = SAT_LO[INT_W-1:0];
		end else begin
			int_sat = int_sum[INT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			vi_q        <= '0;
			ci_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IFIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_VLOOP;
						cnt_q   <= '0;
					end
				end
				ST_VLOOP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_VFIN;
					end
				end
				ST_VFIN: begin
					vi_q    <= int_sat;
					state_q <= ST_VLOAD;
				end
				ST_VLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_ILOOP;
				end
				ST_ILOOP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_IFIN;
					end
				end
				ST_IFIN: begin
					if (slot_free) begin
						ci_q    <= int_sat;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			i_q <= i_in;
		end
		if (state_q == ST_VFIN) begin
			iref_q  <= iref_d;
			rclip_q <= rclip_d;
		end
		if (state_q == ST_IFIN && slot_free) begin
			duty_q       <= duty_d;
			cref_q       <= iref_q;
			oref_clip_q  <= rclip_q;
			oduty_clip_q <= dclip_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, cref_q, duty_q};
	assign m_axis_tuser  = {oduty_clip_q, oref_clip_q};

endmodule

// File: rtl/core/cpdc_chk.sv
module cpdc_chk import cpdc_pkg::*; (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [31:0]                       m_axis_tdata,
	input logic [1:0]                        m_axis_tuser
);

	// a stalled result keeps its valid and payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// one sample in flight: no transfer right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	// duty never exceeds 1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:0] <= DUTY_MAX)
		else $error("duty above 1.0");

	// a clamped duty sits on one of its bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tdata[15:0] == '0 || m_axis_tdata[15:0] == DUTY_MAX)
		else $error("clamped duty off its bounds");

endmodule

bind cascaded_pi_duty_controller_unit cpdc_chk u_cpdc_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
